// ===== sv/cfe_pkg.sv =====
// Shared types, constants and fixed-point helpers for the cross field encoder.
// No dependencies; imported by the top level, cfe_isqrt and cfe_div.
`timescale 1ns / 1ps

package cfe_pkg;

    // Fraction bits of the normal, the tangent axes and the result.
    localparam int FRACTION_BITS = 14;
    // Magnitude limit after a group shrink is 2^SHRINK_BITS.
    localparam int SHRINK_BITS = 30;
    // Unit value of the result format.
    localparam logic signed [15:0] RESULT_ONE = 16'sd16384;
    // Configuration register indexes.
    localparam logic [1:0] REG_EPSILON = 2'd0;

    // Flags and magnitudes that travel with an item through the back end.
    typedef struct packed {
        logic        inv;
        logic        zero;
        logic        sx;
        logic        sy;
        logic [29:0] mx;
        logic [29:0] my;
    } t_side;

    // Magnitude of a signed 64-bit value.
    function automatic logic [63:0] f_mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Smallest right shift that brings a group's largest magnitude below the limit.
    // The bit length of the OR of all magnitudes equals that of the largest one.
    function automatic logic [5:0] f_shamt(input logic [63:0] orv);
        logic [6:0] blen;
        blen = 7'd0;
        for (int i = 0; i < 64; i++) begin
            if (orv[i]) begin
                blen = 7'(i + 1);
            end
        end
        if (blen > 7'(SHRINK_BITS)) begin
            return 6'(blen - 7'(SHRINK_BITS));
        end
        return 6'd0;
    endfunction

    // Shift a magnitude right and put the sign back, truncating toward zero.
    function automatic logic signed [30:0] f_shrink(input logic signed [63:0] v,
                                                    input logic [5:0] s);
        logic [63:0]        m;
        logic signed [30:0] ms;
        m  = f_mag(v) >> s;
        ms = $signed(m[30:0]);
        return v[63] ? -ms : ms;
    endfunction

endpackage

// ===== sv/cross_field_encoder_unit.sv =====
// Top level of the four-fold cross field encoder: front-end arithmetic pipeline,
// configuration register, output stage. Depends on cfe_pkg, cfe_isqrt and cfe_div.
`timescale 1ns / 1ps

// The encoder takes one direction and face basis per clock and returns the unit
// cross vector (cos 4theta, sin 4theta) in Q1.14 with a valid flag. Every item
// passes from input transfer to output transfer through 16 stages of projection,
// squaring and group shrinking, 32 stages of square root (one root bit per stage),
// 16 stages of division (one quotient bit per stage) and the output register.
// A new item can be accepted every cycle; a stall on the output holds the whole
// pipeline. Epsilon must be written only while no item is in flight.

module cross_field_encoder_unit
    import cfe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [23:0] i_dir_x,
    input  logic signed [23:0] i_dir_y,
    input  logic signed [23:0] i_dir_z,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic signed [15:0] i_axis_u_x,
    input  logic signed [15:0] i_axis_u_y,
    input  logic signed [15:0] i_axis_u_z,
    input  logic signed [15:0] i_axis_v_x,
    input  logic signed [15:0] i_axis_v_y,
    input  logic signed [15:0] i_axis_v_z,
    // Output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_cross_cos,
    output logic signed [15:0] o_cross_sin,
    output logic               o_cross_valid
);

    logic [14:0]        r_epsilon;
    logic               w_sel_eps;
    logic               w_en;
    logic [16:1]        r_vld;

    logic signed [23:0] w_d [0:2];
    logic signed [15:0] w_n [0:2];
    logic signed [15:0] w_u [0:2];
    logic signed [15:0] w_w [0:2];

    // Configuration register.
    assign pready    = 1'b1;
    assign w_sel_eps = ((paddr >> 2) == REG_EPSILON);
    assign prdata    = w_sel_eps ? {17'd0, r_epsilon} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epsilon <= 15'd1;
        end else if (psel && penable && pwrite && pready && w_sel_eps) begin
            r_epsilon <= pwdata[14:0];
        end
    end

    // The pipeline moves unless a finished result waits on a stalled output.
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[15:1], i_valid};
        end
    end

    assign w_d = '{i_dir_x, i_dir_y, i_dir_z};
    assign w_n = '{i_normal_x, i_normal_y, i_normal_z};
    assign w_u = '{i_axis_u_x, i_axis_u_y, i_axis_u_z};
    assign w_w = '{i_axis_v_x, i_axis_v_y, i_axis_v_z};

    // ---------------- Stage 1: first products ----------------
    logic signed [23:0] r_s1_d   [0:2];
    logic signed [15:0] r_s1_n   [0:2];
    logic signed [15:0] r_s1_u   [0:2];
    logic signed [15:0] r_s1_w   [0:2];
    logic [30:0]        r_s1_nsq [0:2];
    logic signed [39:0] r_s1_pd  [0:2];
    logic signed [39:0] r_s1_cr  [0:5];
    logic signed [31:0] n_s1_nsq [0:2];
    logic signed [39:0] n_s1_pd  [0:2];
    logic signed [39:0] n_s1_cr  [0:5];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s1_nsq[k] = w_n[k] * w_n[k];
            n_s1_pd[k]  = w_d[k] * w_n[k];
        end
        n_s1_cr[0] = w_d[1] * w_n[2];
        n_s1_cr[1] = w_d[2] * w_n[1];
        n_s1_cr[2] = w_d[2] * w_n[0];
        n_s1_cr[3] = w_d[0] * w_n[2];
        n_s1_cr[4] = w_d[0] * w_n[1];
        n_s1_cr[5] = w_d[1] * w_n[0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_s1_d[k]   <= w_d[k];
                r_s1_n[k]   <= w_n[k];
                r_s1_u[k]   <= w_u[k];
                r_s1_w[k]   <= w_w[k];
                r_s1_nsq[k] <= n_s1_nsq[k][30:0];
                r_s1_pd[k]  <= n_s1_pd[k];
            end
            for (int k = 0; k < 6; k++) begin
                r_s1_cr[k] <= n_s1_cr[k];
            end
        end
    end

    // ---------------- Stage 2: |n|^2, d x n, d.n, epsilon^2 ----------------
    logic signed [23:0] r_s2_d [0:2];
    logic signed [15:0] r_s2_n [0:2];
    logic signed [15:0] r_s2_u [0:2];
    logic signed [15:0] r_s2_w [0:2];
    logic [31:0]        r_s2_nn;
    logic signed [40:0] r_s2_c [0:2];
    logic signed [41:0] r_s2_p;
    logic [29:0]        r_s2_e2;
    logic               r_s2_ebig;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_s2_d[k] <= r_s1_d[k];
                r_s2_n[k] <= r_s1_n[k];
                r_s2_u[k] <= r_s1_u[k];
                r_s2_w[k] <= r_s1_w[k];
            end
            r_s2_nn   <= 32'(r_s1_nsq[0]) + 32'(r_s1_nsq[1]) + 32'(r_s1_nsq[2]);
            r_s2_c[0] <= 41'(r_s1_cr[0]) - 41'(r_s1_cr[1]);
            r_s2_c[1] <= 41'(r_s1_cr[2]) - 41'(r_s1_cr[3]);
            r_s2_c[2] <= 41'(r_s1_cr[4]) - 41'(r_s1_cr[5]);
            r_s2_p    <= 42'(r_s1_pd[0]) + 42'(r_s1_pd[1]) + 42'(r_s1_pd[2]);
            r_s2_e2   <= 30'(r_epsilon) * 30'(r_epsilon);
            r_s2_ebig <= (r_epsilon >= 15'(1 << FRACTION_BITS));
        end
    end

    // ---------------- Stage 3: squares of d x n, threshold, projection products
    logic signed [15:0] r_s3_u   [0:2];
    logic signed [15:0] r_s3_w   [0:2];
    logic [61:0]        r_s3_csq [0:2];
    logic               r_s3_big;
    logic               r_s3_inv;
    logic [59:0]        r_s3_rb;
    logic signed [56:0] r_s3_dn  [0:2];
    logic signed [57:0] r_s3_np  [0:2];
    logic [40:0]        n_s3_cm  [0:2];
    logic signed [56:0] n_s3_dn  [0:2];
    logic signed [57:0] n_s3_np  [0:2];
    logic signed [32:0] w_s3_nn;

    assign w_s3_nn = $signed({1'b0, r_s2_nn});

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s3_cm[k] = r_s2_c[k][40] ? 41'(-r_s2_c[k]) : 41'(r_s2_c[k]);
            n_s3_dn[k] = r_s2_d[k] * w_s3_nn;
            n_s3_np[k] = r_s2_n[k] * r_s2_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_s3_u[k]   <= r_s2_u[k];
                r_s3_w[k]   <= r_s2_w[k];
                r_s3_csq[k] <= 62'(n_s3_cm[k][30:0]) * 62'(n_s3_cm[k][30:0]);
                r_s3_dn[k]  <= n_s3_dn[k];
                r_s3_np[k]  <= n_s3_np[k];
            end
            // A component of d x n at 2^31 or more already exceeds the threshold.
            r_s3_big <= (|n_s3_cm[0][40:31]) || (|n_s3_cm[1][40:31])
                        || (|n_s3_cm[2][40:31]);
            r_s3_inv <= r_s2_ebig || ({2'b00, r_s2_nn} <= 34'(r_s2_e2));
            r_s3_rb  <= 60'(r_s2_nn) * 60'(r_s2_e2[27:0]);
        end
    end

    // ---------------- Stage 4: short projection test, scaled tangent ----------
    logic signed [15:0] r_s4_u [0:2];
    logic signed [15:0] r_s4_w [0:2];
    logic signed [58:0] r_s4_t [0:2];
    logic               r_s4_inv;
    logic [63:0]        w_s4_left;
    logic [63:0]        w_s4_right;

    assign w_s4_left  = 64'(r_s3_csq[0]) + 64'(r_s3_csq[1]) + 64'(r_s3_csq[2]);
    assign w_s4_right = {2'b00, r_s3_rb, 2'b00};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_s4_u[k] <= r_s3_u[k];
                r_s4_w[k] <= r_s3_w[k];
                r_s4_t[k] <= 59'(r_s3_dn[k]) - 59'(r_s3_np[k]);
            end
            r_s4_inv <= r_s3_inv || (!r_s3_big && (w_s4_left <= w_s4_right));
        end
    end

    // ---------------- Stage 5: shrink the tangent ----------------
    logic signed [15:0] r_s5_u [0:2];
    logic signed [15:0] r_s5_w [0:2];
    logic signed [30:0] r_s5_t [0:2];
    logic               r_s5_inv;
    logic [5:0]         w_s5_sh;

    assign w_s5_sh = f_shamt(f_mag(64'(r_s4_t[0])) | f_mag(64'(r_s4_t[1]))
                             | f_mag(64'(r_s4_t[2])));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_s5_u[k] <= r_s4_u[k];
                r_s5_w[k] <= r_s4_w[k];
                r_s5_t[k] <= f_shrink(64'(r_s4_t[k]), w_s5_sh);
            end
            r_s5_inv <= r_s4_inv;
        end
    end

    // ---------------- Stage 6: products with the tangent axes ----------------
    logic signed [45:0] r_s6_pa [0:2];
    logic signed [45:0] r_s6_pb [0:2];
    logic               r_s6_inv;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_s6_pa[k] <= r_s5_t[k] * r_s5_u[k];
                r_s6_pb[k] <= r_s5_t[k] * r_s5_w[k];
            end
            r_s6_inv <= r_s5_inv;
        end
    end

    // ---------------- Stage 7: A = t.u, B = t.v ----------------
    logic signed [47:0] r_s7_a;
    logic signed [47:0] r_s7_b;
    logic               r_s7_inv;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s7_a   <= 48'(r_s6_pa[0]) + 48'(r_s6_pa[1]) + 48'(r_s6_pa[2]);
            r_s7_b   <= 48'(r_s6_pb[0]) + 48'(r_s6_pb[1]) + 48'(r_s6_pb[2]);
            r_s7_inv <= r_s6_inv;
        end
    end

    // ---------------- Stage 8: shrink (A, B) ----------------
    logic signed [30:0] r_s8_a;
    logic signed [30:0] r_s8_b;
    logic               r_s8_inv;
    logic               r_s8_zero;
    logic [5:0]         w_s8_sh;

    assign w_s8_sh = f_shamt(f_mag(64'(r_s7_a)) | f_mag(64'(r_s7_b)));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s8_a    <= f_shrink(64'(r_s7_a), w_s8_sh);
            r_s8_b    <= f_shrink(64'(r_s7_b), w_s8_sh);
            r_s8_inv  <= r_s7_inv;
            r_s8_zero <= (r_s7_a == '0) && (r_s7_b == '0);
        end
    end

    // ---------------- Stages 9 to 11: first complex squaring ----------------
    logic signed [61:0] r_s9_aa;
    logic signed [61:0] r_s9_bb;
    logic signed [61:0] r_s9_ab;
    logic signed [62:0] r_s10_z0;
    logic signed [62:0] r_s10_z1;
    logic signed [30:0] r_s11_z0;
    logic signed [30:0] r_s11_z1;
    logic [5:0]         w_s11_sh;
    logic [4:0]         r_inv_p;
    logic [4:0]         r_zero_p;

    assign w_s11_sh = f_shamt(f_mag(64'(r_s10_z0)) | f_mag(64'(r_s10_z1)));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s9_aa  <= r_s8_a * r_s8_a;
            r_s9_bb  <= r_s8_b * r_s8_b;
            r_s9_ab  <= r_s8_a * r_s8_b;
            r_s10_z0 <= 63'(r_s9_aa) - 63'(r_s9_bb);
            r_s10_z1 <= 63'(r_s9_ab) <<< 1;
            r_s11_z0 <= f_shrink(64'(r_s10_z0), w_s11_sh);
            r_s11_z1 <= f_shrink(64'(r_s10_z1), w_s11_sh);
        end
    end

    // ---------------- Stages 12 to 14: second complex squaring ----------------
    logic signed [61:0] r_s12_aa;
    logic signed [61:0] r_s12_bb;
    logic signed [61:0] r_s12_ab;
    logic signed [62:0] r_s13_z0;
    logic signed [62:0] r_s13_z1;
    logic signed [30:0] w_s14_x;
    logic signed [30:0] w_s14_y;
    logic [5:0]         w_s14_sh;
    t_side              r_s14_side;

    assign w_s14_sh = f_shamt(f_mag(64'(r_s13_z0)) | f_mag(64'(r_s13_z1)));
    assign w_s14_x  = f_shrink(64'(r_s13_z0), w_s14_sh);
    assign w_s14_y  = f_shrink(64'(r_s13_z1), w_s14_sh);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s12_aa <= r_s11_z0 * r_s11_z0;
            r_s12_bb <= r_s11_z1 * r_s11_z1;
            r_s12_ab <= r_s11_z0 * r_s11_z1;
            r_s13_z0 <= 63'(r_s12_aa) - 63'(r_s12_bb);
            r_s13_z1 <= 63'(r_s12_ab) <<< 1;
            r_s14_side.inv  <= r_inv_p[4];
            r_s14_side.zero <= r_zero_p[4];
            r_s14_side.sx   <= w_s14_x[30];
            r_s14_side.sy   <= w_s14_y[30];
            r_s14_side.mx   <= w_s14_x[30] ? 30'(-w_s14_x) : w_s14_x[29:0];
            r_s14_side.my   <= w_s14_y[30] ? 30'(-w_s14_y) : w_s14_y[29:0];
        end
    end

    // Flags from stage 8 follow the squarings through stages 9 to 13.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_inv_p  <= {r_inv_p[3:0], r_s8_inv};
            r_zero_p <= {r_zero_p[3:0], r_s8_zero};
        end
    end

    // ---------------- Stages 15 and 16: X^2 + Y^2 ----------------
    logic [59:0] r_s15_xx;
    logic [59:0] r_s15_yy;
    t_side       r_s15_side;
    logic [61:0] r_s16_sum;
    t_side       r_s16_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s15_xx   <= 60'(r_s14_side.mx) * 60'(r_s14_side.mx);
            r_s15_yy   <= 60'(r_s14_side.my) * 60'(r_s14_side.my);
            r_s15_side <= r_s14_side;
            r_s16_sum  <= 62'(r_s15_xx) + 62'(r_s15_yy);
            r_s16_side <= r_s15_side;
        end
    end

    // ---------------- Length and division ----------------
    logic        w_sq_vld;
    logic [30:0] w_sq_root;
    t_side       w_sq_side;
    logic        w_dv_vld;
    logic [14:0] w_dv_qc;
    logic [14:0] w_dv_qs;
    t_side       w_dv_side;

    cfe_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_vld[16]),
        .i_x     (r_s16_sum),
        .i_side  (r_s16_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    cfe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq_vld),
        .i_len   (w_sq_root),
        .i_side  (w_sq_side),
        .o_vld   (w_dv_vld),
        .o_q_cos (w_dv_qc),
        .o_q_sin (w_dv_qs),
        .o_side  (w_dv_side)
    );

    // ---------------- Output register ----------------
    logic               r_out_vld;
    logic signed [15:0] r_out_cos;
    logic signed [15:0] r_out_sin;
    logic               r_out_cv;
    logic signed [15:0] w_qc;
    logic signed [15:0] w_qs;

    assign w_qc = w_dv_side.sx ? -$signed({1'b0, w_dv_qc}) : $signed({1'b0, w_dv_qc});
    assign w_qs = w_dv_side.sy ? -$signed({1'b0, w_dv_qs}) : $signed({1'b0, w_dv_qs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dv_vld;
        end
    end

    // Degenerate items give zero; a projection orthogonal to both axes gives angle 0.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_cv <= !w_dv_side.inv;
            if (w_dv_side.inv) begin
                r_out_cos <= '0;
                r_out_sin <= '0;
            end else if (w_dv_side.zero) begin
                r_out_cos <= RESULT_ONE;
                r_out_sin <= '0;
            end else begin
                r_out_cos <= w_qc;
                r_out_sin <= w_qs;
            end
        end
    end

    assign o_valid       = r_out_vld;
    assign o_cross_cos   = r_out_cos;
    assign o_cross_sin   = r_out_sin;
    assign o_cross_valid = r_out_cv;

endmodule

// ===== sv/cfe_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, for the encoder.
// Depends on cfe_pkg for the sideband type.
`timescale 1ns / 1ps

module cfe_isqrt
    import cfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [61:0] i_x,
    input  t_side       i_side,
    output logic        o_vld,
    output logic [30:0] o_root,
    output t_side       o_side
);

    logic [61:0] r_x    [0:31];
    logic [61:0] r_r    [0:31];
    t_side       r_side [0:31];
    logic [31:0] r_vld;
    logic [61:0] n_x    [1:31];
    logic [61:0] n_r    [1:31];

    // One digit step per stage; each stage tests a fixed power of four.
    always_comb begin
        logic [62:0] trial;
        for (int i = 0; i < 31; i++) begin
            trial = {1'b0, r_r[i]} + (63'd1 << (60 - 2 * i));
            if ({1'b0, r_x[i]} >= trial) begin
                n_x[i + 1] = 62'({1'b0, r_x[i]} - trial);
                n_r[i + 1] = (r_r[i] >> 1) + (62'd1 << (60 - 2 * i));
            end else begin
                n_x[i + 1] = r_x[i];
                n_r[i + 1] = r_r[i] >> 1;
            end
        end
    end

    // Valid bits move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[30:0], i_vld};
        end
    end

    // Data stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= i_x;
            r_r[0]    <= '0;
            r_side[0] <= i_side;
            for (int i = 1; i < 32; i++) begin
                r_x[i]    <= n_x[i];
                r_r[i]    <= n_r[i];
                r_side[i] <= r_side[i - 1];
            end
        end
    end

    assign o_vld  = r_vld[31];
    assign o_root = r_r[31][30:0];
    assign o_side = r_side[31];

endmodule

// ===== sv/cfe_div.sv =====
// Pipelined restoring divider that scales both components by 1/length with rounding.
// Depends on cfe_pkg for the sideband type.
`timescale 1ns / 1ps

module cfe_div
    import cfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [30:0] i_len,
    input  t_side       i_side,
    output logic        o_vld,
    output logic [14:0] o_q_cos,
    output logic [14:0] o_q_sin,
    output t_side       o_side
);

    logic [46:0] r_rc   [0:15];
    logic [46:0] r_rs   [0:15];
    logic [14:0] r_qc   [0:15];
    logic [14:0] r_qs   [0:15];
    logic [31:0] r_d    [0:15];
    t_side       r_side [0:15];
    logic [15:0] r_vld;
    logic [46:0] n_rc   [1:15];
    logic [46:0] n_rs   [1:15];
    logic [14:0] n_qc   [1:15];
    logic [14:0] n_qs   [1:15];
    logic [30:0] w_len;

    // A zero length is treated as one.
    assign w_len = (i_len == '0) ? 31'd1 : i_len;

    // One quotient bit per stage, most significant first.
    always_comb begin
        logic [46:0] dsh;
        for (int j = 0; j < 15; j++) begin
            dsh = 47'(r_d[j]) << (14 - j);
            if (r_rc[j] >= dsh) begin
                n_rc[j + 1] = r_rc[j] - dsh;
                n_qc[j + 1] = {r_qc[j][13:0], 1'b1};
            end else begin
                n_rc[j + 1] = r_rc[j];
                n_qc[j + 1] = {r_qc[j][13:0], 1'b0};
            end
            if (r_rs[j] >= dsh) begin
                n_rs[j + 1] = r_rs[j] - dsh;
                n_qs[j + 1] = {r_qs[j][13:0], 1'b1};
            end else begin
                n_rs[j + 1] = r_rs[j];
                n_qs[j + 1] = {r_qs[j][13:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[14:0], i_vld};
        end
    end

    // Stage zero forms (m * 2^(F+1) + len) over (2 * len).
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rc[0]   <= (47'(i_side.mx) << (FRACTION_BITS + 1)) + 47'(w_len);
            r_rs[0]   <= (47'(i_side.my) << (FRACTION_BITS + 1)) + 47'(w_len);
            r_qc[0]   <= '0;
            r_qs[0]   <= '0;
            r_d[0]    <= {w_len, 1'b0};
            r_side[0] <= i_side;
            for (int j = 1; j < 16; j++) begin
                r_rc[j]   <= n_rc[j];
                r_rs[j]   <= n_rs[j];
                r_qc[j]   <= n_qc[j];
                r_qs[j]   <= n_qs[j];
                r_d[j]    <= r_d[j - 1];
                r_side[j] <= r_side[j - 1];
            end
        end
    end

    assign o_vld   = r_vld[15];
    assign o_q_cos = r_qc[15];
    assign o_q_sin = r_qs[15];
    assign o_side  = r_side[15];

endmodule

// ===== sv/cfe_checker.sv =====
// Port-level checks for the cross field encoder, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module cfe_assertions (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_cross_cos,
    input logic signed [15:0] o_cross_sin,
    input logic               o_cross_valid
);

    // A result held by a stall keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_cross_cos) && $stable(o_cross_sin)
                                  && $stable(o_cross_valid)))
        else $error("stalled result changed");

    // A degenerate result carries zero components.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_cross_valid) |-> (o_cross_cos == 16'sd0 && o_cross_sin == 16'sd0))
        else $error("degenerate result is not zero");

    // A valid result stays within the unit range.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cross_valid) |->
            (o_cross_cos <= 16'sd16384 && o_cross_cos >= -16'sd16384
             && o_cross_sin <= 16'sd16384 && o_cross_sin >= -16'sd16384))
        else $error("result out of unit range");

    // Reset empties the output stage.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind cross_field_encoder_unit cfe_assertions u_cfe_assertions (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_cross_cos   (o_cross_cos),
    .o_cross_sin   (o_cross_sin),
    .o_cross_valid (o_cross_valid)
);
